FILE: rtl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg - multichannel FIR smoother package
// Item types, field widths, coefficient reset value and the constants for the
// fixed divide by ten thousand.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int CH_W        = 2;
  localparam int SMP_W       = 16;
  localparam int COEF_W      = 16;
  localparam int NUM_COEFS   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int TAPS_DEF    = 5;
  localparam int CHANNELS_DEF = 4;

  localparam logic signed [COEF_W-1:0] COEF_RESET = 16'sd2000;

  // sample*coef, sample taken as unsigned
  localparam int PROD_W = SMP_W + COEF_W + 1;
  // |sample*coef| <= 65535*32768 < 2^31
  localparam int MAG_W  = 31;
  // x/10000 == (x*DIV_MAGIC) >> DIV_SHIFT, exact for x < 2^31
  localparam int MAGIC_W   = 32;
  localparam int DIV_SHIFT = 45;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 32'd3518437209;
  localparam int Q_W = MAG_W + MAGIC_W - DIV_SHIFT;

  localparam logic [SMP_W-1:0] OUT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [SMP_W-1:0] filtered;
  } out_item_t;

endpackage

FILE: rtl/multichannel_fir_smoother.sv
// ----------------------------------------------------------------------------
// multichannel_fir_smoother - per-channel FIR smoother for temperature samples
// Weighted TAPS-sample window per channel, history kept in one row-wide memory.
// ----------------------------------------------------------------------------
// Accepts one item per cycle, back to back, on any mix of channels; each item
// gives one result. Accepting an item registers it and reads its channel's
// row; stage B then registers the tap products, stage C the quotients by ten
// thousand, and the output register the summed, clamped value. Up to four
// items are in flight; in_ready drops only while the output register is held
// by out_ready and every stage behind it is full. The history memory holds
// one row of TAPS-1 samples per channel: a row is read when the item is
// accepted and written back when the item leaves stage A, and a one-entry
// bypass covers an item of the same channel that follows right behind. Rows
// come out of reset empty through per-row valid bits, so no clearing pass is
// needed. Each tap term is sample*coef/10000 truncated toward zero; the sum
// is clamped to 0..65535. A channel number at or above CHANNELS returns
// filtered = 0 and leaves the history alone. Coefficients beyond coef_4 are
// zero. Write coefficients only while no item is in flight.
module multichannel_fir_smoother #(
  parameter int TAPS     = mfs_pkg::TAPS_DEF,
  parameter int CHANNELS = mfs_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mfs_pkg::in_item_t          in_item,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output mfs_pkg::out_item_t         out_item,
  // coefficient writes
  input  logic                       cfg_we,
  input  logic [mfs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mfs_pkg::COEF_W-1:0] cfg_wdata
);
  import mfs_pkg::*;

  localparam int HIST  = TAPS - 1;
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = Q_W + 1 + $clog2(TAPS);

  typedef logic [HIST-1:0][SMP_W-1:0] row_t;

  // --------------------------------------------------------------------------
  // coefficient registers
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_r [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_r[i] <= COEF_RESET;
    end else if (cfg_we && (32'(cfg_idx) < NUM_COEFS)) begin
      coef_r[cfg_idx] <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow: each stage moves when the one after it is empty or moving
  // --------------------------------------------------------------------------
  logic a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic en_a, en_b, en_c, en_out;
  logic in_fire;

  assign en_out  = !out_vld_r || out_ready;
  assign en_c    = !c_vld_r || en_out;
  assign en_b    = !b_vld_r || en_c;
  assign en_a    = !a_vld_r || en_b;
  assign in_ready = en_a;
  assign in_fire = in_valid && en_a;

  // --------------------------------------------------------------------------
  // history memory, one row per channel, registered read
  // --------------------------------------------------------------------------
  row_t              hist_mem [CHANNELS];
  row_t              hist_rd_r;
  logic [CH_AW-1:0]  rd_addr;
  logic [CH_AW-1:0]  wr_addr;
  logic              wr_en;
  row_t              wr_row;

  assign rd_addr = CH_AW'(in_item.channel);

  // read data holds while stage A is stalled
  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= wr_row;
    if (en_a)  hist_rd_r <= hist_mem[rd_addr];
  end

  logic [CHANNELS-1:0] row_vld_r;   // row written since reset

  // last row written, for an item of the same channel right behind
  logic             last_vld_r;
  logic [CH_AW-1:0] last_ch_r;
  row_t             last_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      last_vld_r <= 1'b0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
      last_vld_r         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_ch_r  <= wr_addr;
      last_row_r <= wr_row;
    end
  end

  // --------------------------------------------------------------------------
  // stage A: window assembly, history write-back, tap products
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]  a_ch_r;
  logic [SMP_W-1:0] a_smp_r;
  logic             a_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en_a) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ch_r  <= in_item.channel;
      a_smp_r <= in_item.sample;
      a_inr_r <= (32'(in_item.channel) < CHANNELS);
    end
  end

  logic [CH_AW-1:0]  a_addr;
  row_t              hist_row;
  logic [SMP_W-1:0]  win [TAPS];

  assign a_addr = CH_AW'(a_ch_r);

  always_comb begin
    if (last_vld_r && (last_ch_r == a_addr)) hist_row = last_row_r;
    else if (row_vld_r[a_addr])              hist_row = hist_rd_r;
    else                                     hist_row = '0;
    win[0] = a_smp_r;
    for (int k = 1; k < TAPS; k++) win[k] = hist_row[HIST-k];
    for (int j = 0; j < HIST - 1; j++) wr_row[j] = hist_row[j+1];
    wr_row[HIST-1] = a_smp_r;
  end

  assign wr_en   = a_vld_r && a_inr_r && en_b;
  assign wr_addr = a_addr;

  logic signed [PROD_W-1:0] a_prod [TAPS];

  for (genvar k = 0; k < TAPS; k++) begin : g_prod
    logic signed [SMP_W:0]    smp_s;
    logic signed [COEF_W-1:0] wgt;
    assign smp_s = $signed({1'b0, win[k]});
    if (k < NUM_COEFS) begin : g_w
      assign wgt = coef_r[k];
    end else begin : g_z
      assign wgt = '0;
    end
    assign a_prod[k] = PROD_W'(smp_s) * PROD_W'(wgt);
  end

  logic signed [PROD_W-1:0] b_prod_r [TAPS];
  logic [CH_W-1:0]          b_ch_r;
  logic                     b_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en_b) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en_b && a_vld_r) begin
      for (int k = 0; k < TAPS; k++) b_prod_r[k] <= a_prod[k];
      b_ch_r  <= a_ch_r;
      b_inr_r <= a_inr_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage B: magnitude / 10000 by reciprocal multiply, sign kept aside
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]   b_quo [TAPS];
  logic [TAPS-1:0]  b_neg;

  for (genvar k = 0; k < TAPS; k++) begin : g_div
    logic [PROD_W-1:0]          mag_full;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+MAGIC_W-1:0]   scaled;
    assign b_neg[k]  = b_prod_r[k][PROD_W-1];
    assign mag_full  = b_neg[k] ? PROD_W'(-b_prod_r[k]) : PROD_W'(b_prod_r[k]);
    assign mag       = mag_full[MAG_W-1:0];
    assign scaled    = (MAG_W+MAGIC_W)'(mag) * (MAG_W+MAGIC_W)'(DIV_MAGIC);
    assign b_quo[k]  = scaled[MAG_W+MAGIC_W-1:DIV_SHIFT];
  end

  logic [Q_W-1:0]   c_quo_r [TAPS];
  logic [TAPS-1:0]  c_neg_r;
  logic [CH_W-1:0]  c_ch_r;
  logic             c_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en_c) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en_c && b_vld_r) begin
      for (int k = 0; k < TAPS; k++) c_quo_r[k] <= b_quo[k];
      c_neg_r <= b_neg;
      c_ch_r  <= b_ch_r;
      c_inr_r <= b_inr_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage C: signed sum of the terms, zero for an out-of-range channel, else clamp to 0..65535
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] c_sum;
  logic [SMP_W-1:0]        c_filt;

  always_comb begin
    logic signed [SUM_W-1:0] term;
    c_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      term  = $signed(SUM_W'(c_quo_r[k]));
      c_sum = c_sum + (c_neg_r[k] ? -term : term);
    end
    if (!c_inr_r)                                 c_filt = '0;
    else if (c_sum < 0)                           c_filt = '0;
    else if (c_sum > $signed(SUM_W'(OUT_MAX)))    c_filt = OUT_MAX;
    else                                          c_filt = c_sum[SMP_W-1:0];
  end

  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en_out) out_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en_out && c_vld_r) begin
      out_item_r.out_channel <= c_ch_r;
      out_item_r.filtered    <= c_filt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !(32'(out_item_r.out_channel) < CHANNELS) |-> out_item_r.filtered == '0)
    else $error("out-of-range channel gave a nonzero result");

  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_vld_r[$past(wr_addr)] && last_vld_r && last_ch_r == $past(wr_addr))
    else $error("history write not recorded in valid bits or bypass");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> in_ready)
    else $error("input stalled with stage A empty");

endmodule
